@@ rtl/jsf_pkg.sv @@
`default_nettype none

package jsf_pkg;

    localparam int BYTE_W  = 8;
    localparam int DEPTH_W = 8;

    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_DISCARD = 3'b010,
        MODE_OBJECT  = 3'b100
    } frame_mode_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              ovf;
    } jsf_result_t;

endpackage

`default_nettype wire

@@ rtl/jsf_core.sv @@
`default_nettype none

module jsf_core #(
    parameter int MAX_DEPTH = 255
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      step_en,
    input  wire logic [jsf_pkg::BYTE_W-1:0] step_byte,
    output jsf_pkg::jsf_result_t           result
);
    import jsf_pkg::*;

    localparam logic [DEPTH_W-1:0] DEPTH_CAP =
        (MAX_DEPTH > 255) ? 8'd255 : DEPTH_W'(MAX_DEPTH);

    frame_mode_t        mode_reg, mode_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               str_reg, str_next;
    logic               esc_reg, esc_next;
    logic [DEPTH_W-1:0] depth_dec;
    logic               is_blank;

    assign is_blank  = (step_byte == CH_SPACE) || (step_byte == CH_TAB) ||
                       (step_byte == CH_CR) || (step_byte == CH_LF);
    assign depth_dec = (depth_reg != '0) ? depth_reg - 1'b1 : depth_reg;

    always_comb begin
        mode_next    = mode_reg;
        depth_next   = depth_reg;
        str_next     = str_reg;
        esc_next     = esc_reg;
        result.valid = 1'b0;
        result.data  = step_byte;
        result.last  = 1'b0;
        result.ovf   = 1'b0;
        unique case (mode_reg)
            MODE_DISCARD: begin
                if (step_byte == CH_LF) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_OBJECT: begin
                result.valid = step_en;
                priority if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (step_byte == CH_BSLASH) begin
                    esc_next = 1'b1;
                end else if (step_byte == CH_QUOTE) begin
                    str_next = !str_reg;
                end else if (!str_reg && step_byte == CH_LBRACE) begin
                    if (depth_reg >= DEPTH_CAP) begin
                        depth_next = DEPTH_CAP;
                        result.ovf = 1'b1;
                    end else begin
                        depth_next = depth_reg + 1'b1;
                    end
                end else if (!str_reg && step_byte == CH_RBRACE) begin
                    depth_next = depth_dec;
                    if (depth_dec == '0) begin
                        result.last = 1'b1;
                        mode_next   = MODE_IDLE;
                        str_next    = 1'b0;
                        esc_next    = 1'b0;
                    end
                end else begin
                    esc_next = 1'b0;
                end
            end
            default: begin
                if (is_blank) begin
                    mode_next = MODE_IDLE;
                end else if (step_byte == CH_LBRACE) begin
                    mode_next    = MODE_OBJECT;
                    depth_next   = DEPTH_W'(1);
                    str_next     = 1'b0;
                    esc_next     = 1'b0;
                    result.valid = step_en;
                end else begin
                    mode_next = MODE_DISCARD;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            depth_reg <= '0;
            str_reg   <= 1'b0;
            esc_reg   <= 1'b0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            depth_reg <= depth_next;
            str_reg   <= str_next;
            esc_reg   <= esc_next;
        end
    end

    a_depth_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_CAP)
        else $error("nest depth above cap");

    a_depth_zero_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != MODE_OBJECT |-> depth_reg == '0)
        else $error("nonzero depth outside object");

    a_depth_nonzero_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_OBJECT |-> depth_reg != '0)
        else $error("zero depth inside object");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && result.valid && result.last |=> mode_reg == MODE_IDLE && !str_reg)
        else $error("object end did not return to idle");

endmodule

`default_nettype wire

@@ rtl/jsf_out_stage.sv @@
`default_nettype none

module jsf_out_stage (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire jsf_pkg::jsf_result_t       result,
    output logic                            load_ready,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [jsf_pkg::BYTE_W-1:0]      m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);
    import jsf_pkg::*;

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              last_reg;
    logic              ovf_reg;

    assign load_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (result.valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid) begin
            data_reg <= result.data;
            last_reg <= result.last;
            ovf_reg  <= result.ovf;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = ovf_reg;

    a_last_is_rbrace: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && last_reg |-> data_reg == CH_RBRACE)
        else $error("last flag on byte other than closing brace");

    a_ovf_is_lbrace: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && ovf_reg |-> data_reg == CH_LBRACE)
        else $error("overflow flag on byte other than opening brace");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |-> load_ready)
        else $error("result loaded over a held request");

endmodule

`default_nettype wire

@@ rtl/json_object_stream_framer.sv @@
`default_nettype none

// Frames top-level JSON objects out of a byte stream. Each accepted byte is
// one request; the block takes one byte per cycle unless back-pressure on
// m_tready stalls it, and every byte of an object passes through an input
// register, then a result register. The rate rests on the frame mode, brace
// depth and string/escape flags being updated between those two registers.
// Blank bytes while idle are dropped, a stray byte drops everything through
// the next LF, m_tlast marks the closing brace of an object and m_tuser marks
// a '{' at which the depth saturated at MAX_DEPTH (capped at 255).
module json_object_stream_framer #(
    parameter int MAX_DEPTH = 255
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] msg_byte
    output logic            m_tlast,
    output logic            m_tuser    // [0] depth_overflow
);
    import jsf_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_data_reg;
    logic              load_ready;
    logic              advance;
    jsf_result_t       result;

    assign advance  = in_valid_reg && load_ready;
    assign s_tready = !in_valid_reg || load_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    jsf_core #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .step_byte (in_data_reg),
        .result    (result)
    );

    jsf_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .result     (result),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

@@ dv/json_object_stream_framer_checker.sv @@
`timescale 1ns / 100ps

module json_object_stream_framer_checker #(
    parameter int MAX_DEPTH = 255
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,
    input  wire logic       m_tlast,
    input  wire logic       m_tuser,
    output int unsigned     fail_count,
    output int unsigned     due_count
);
    import jsf_pkg::*;

    localparam logic [DEPTH_W-1:0] DEPTH_CAP =
        (MAX_DEPTH > 255) ? 8'd255 : DEPTH_W'(MAX_DEPTH);

    frame_mode_t        mode;
    logic [DEPTH_W-1:0] depth;
    logic               in_str;
    logic               esc_next;
    jsf_result_t        bytes_due[$];
    int unsigned        errs = 0;

    task automatic frame_byte(input logic [7:0] c, output jsf_result_t r);
        r      = '0;
        r.data = c;
        case (mode)
            MODE_DISCARD: begin
                if (c == CH_LF)
                    mode = MODE_IDLE;
            end
            MODE_OBJECT: begin
                r.valid = 1'b1;
                if (esc_next) begin
                    esc_next = 1'b0;
                end else if (c == CH_BSLASH) begin
                    esc_next = 1'b1;
                end else if (c == CH_QUOTE) begin
                    in_str = !in_str;
                end else if (!in_str) begin
                    if (c == CH_LBRACE) begin
                        if (depth >= DEPTH_CAP) begin
                            depth = DEPTH_CAP;
                            r.ovf = 1'b1;
                        end else begin
                            depth = depth + 1'b1;
                        end
                    end else if (c == CH_RBRACE) begin
                        if (depth != '0)
                            depth = depth - 1'b1;
                        if (depth == '0) begin
                            r.last   = 1'b1;
                            mode     = MODE_IDLE;
                            in_str   = 1'b0;
                            esc_next = 1'b0;
                        end
                    end
                end
            end
            default: begin
                if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
                    mode = MODE_IDLE;
                end else if (c != CH_LBRACE) begin
                    mode = MODE_DISCARD;
                end else begin
                    mode     = MODE_OBJECT;
                    depth    = DEPTH_W'(1);
                    in_str   = 1'b0;
                    esc_next = 1'b0;
                    r.valid  = 1'b1;
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        jsf_result_t want;
        if (!aresetn) begin
            mode     = MODE_IDLE;
            depth    = '0;
            in_str   = 1'b0;
            esc_next = 1'b0;
            bytes_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (bytes_due.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected result: data %h last %b ovf %b",
                                 m_tdata, m_tlast, m_tuser);
                end else begin
                    want = bytes_due.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.last ||
                        m_tuser !== want.ovf) begin
                        errs++;
                        if (errs <= 10)
                            $display({"mismatch: expected data %h last %b ovf %b, ",
                                      "got data %h last %b ovf %b"},
                                     want.data, want.last, want.ovf,
                                     m_tdata, m_tlast, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                frame_byte(s_tdata, want);
                if (want.valid)
                    bytes_due.push_back(want);
            end
        end
        fail_count <= errs;
        due_count  <= bytes_due.size();
    end

endmodule

@@ dv/json_object_stream_framer_tb.sv @@
`timescale 1ns / 100ps

module json_object_stream_framer_tb;
    import jsf_pkg::*;

    localparam int MAX_DEPTH    = 255;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 600;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    wire logic   s_tready;
    wire logic   m_tvalid;
    wire logic [7:0] m_tdata;
    wire logic   m_tlast;
    wire logic   m_tuser;
    logic        m_tready = 1'b0;
    logic        idle_on  = 1'b1;

    int unsigned fail_count;
    int unsigned due_count;
    int unsigned cycles = 0;
    int unsigned sent   = 0;
    int          rx_hold = 0;
    int          rx_draw;
    logic [7:0]  burst[$];

    always #5 aclk = ~aclk;

    json_object_stream_framer #(.MAX_DEPTH(MAX_DEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    json_object_stream_framer_checker #(.MAX_DEPTH(MAX_DEPTH)) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .fail_count(fail_count),
        .due_count (due_count)
    );

    // while idle_on is set, hold ready low for a random stall (possibly none) after each accepted result
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                rx_draw = idle_on ? $urandom_range(0, 15) : 0;
                if (rx_draw != 0) begin
                    m_tready <= 1'b0;
                    rx_hold  <= rx_draw - 1;
                end
            end
        end else if (rx_hold == 0) begin
            m_tready <= 1'b1;
        end else begin
            rx_hold <= rx_hold - 1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic flush();
        foreach (burst[i])
            send_byte(burst[i]);
        sent += burst.size();
        burst.delete();
    endtask

    // hold off until every request has drained out of the block
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_LBRACE || c == CH_RBRACE || c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    task automatic add_string();
        logic [7:0] c;
        burst.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 4) == 0) begin
                burst.push_back(CH_BSLASH);
                burst.push_back(8'($urandom_range(0, 255)));
            end else begin
                do c = 8'($urandom_range(0, 255));
                while (c == CH_QUOTE || c == CH_BSLASH);
                burst.push_back(c);
            end
        end
        burst.push_back(CH_QUOTE);
    endtask

    task automatic add_object(input int max_nest, input bit close);
        int d;
        int n;
        d = 1;
        repeat ($urandom_range(0, 2)) burst.push_back(blank_byte());
        burst.push_back(CH_LBRACE);
        n = $urandom_range(0, 12);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    if (d < max_nest) begin
                        burst.push_back(CH_LBRACE);
                        d++;
                    end
                end
                2: begin
                    if (d > 1) begin
                        burst.push_back(CH_RBRACE);
                        d--;
                    end
                end
                3, 4: add_string();
                5: begin
                    burst.push_back(CH_BSLASH);
                    burst.push_back(8'($urandom_range(0, 255)));
                end
                default: burst.push_back(plain_byte());
            endcase
        end
        while (d > 1) begin
            burst.push_back(CH_RBRACE);
            d--;
        end
        if (close)
            burst.push_back(CH_RBRACE);
    endtask

    task automatic add_discard_line();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_LBRACE || c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF);
        burst.push_back(c);
        repeat ($urandom_range(0, 6)) begin
            do c = 8'($urandom_range(0, 255));
            while (c == CH_LF);
            burst.push_back(c);
        end
        burst.push_back(CH_LF);
        if ($urandom_range(0, 1) == 1)
            add_object($urandom_range(1, 4), 1'b1);
    endtask

    task automatic add_deep();
        repeat (DEPTH_W'(255) + 2) burst.push_back(CH_LBRACE);
        add_string();
        repeat (255) burst.push_back(CH_RBRACE);
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        burst = {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_LBRACE, CH_RBRACE,
                 8'h78, CH_LBRACE, CH_LF, CH_LBRACE, CH_BSLASH, CH_RBRACE,
                 CH_QUOTE, CH_LBRACE, CH_BSLASH, CH_QUOTE, CH_QUOTE, CH_RBRACE,
                 CH_RBRACE, 8'hFF, CH_LF, CH_LBRACE, 8'h00, 8'hFF, CH_RBRACE};
        flush();
        drain();

        add_deep();
        flush();

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            idle_on <= ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: add_object($urandom_range(1, 4), 1'b1);
                12, 13, 14: add_discard_line();
                15, 16: repeat ($urandom_range(1, 8)) burst.push_back(8'($urandom_range(0, 255)));
                17: add_object($urandom_range(1, 4), 1'b0);
                default: begin
                    add_object($urandom_range(1, 4), 1'b1);
                    burst.push_back(CH_RBRACE);
                    if ($urandom_range(0, 1) == 1)
                        burst.push_back(CH_LF);
                end
            endcase
            flush();
            if (!paused && sent >= RANDOM_BYTES / 2) begin
                drain();
                paused = 1'b1;
            end
        end

        idle_on <= 1'b1;
        burst.push_back(CH_LF);
        flush();
        drain();

        if (fail_count == 0 && due_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
